### src/egb_pkg.sv
// shared types and constants for the exp-golomb bit packer
package egb_pkg;

    localparam int VALUE_W        = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int BYTE_W         = 8;
    localparam int INDEX_W        = 24;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // input word
    typedef struct packed {
        logic               cmd;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last;
    } t_out_word;

endpackage

### src/egb_front.sv
// front end: accepts words and turns a value into a left-aligned code and its length
module egb_front #(
    parameter int VALUE_BITS = egb_pkg::VALUE_BITS_DEF,
    parameter int CODE_W     = 2 * VALUE_BITS,
    parameter int LEN_W      = $clog2(2 * VALUE_BITS + 1)
) (
    input  logic                i_in_valid,
    input  egb_pkg::t_in_word   i_in_word,
    input  logic                i_q_full,
    output logic                o_in_stall,
    output logic                o_push,
    output logic                o_cmd,
    output logic [CODE_W-1:0]   o_code,
    output logic [LEN_W-1:0]    o_len
);
    import egb_pkg::*;

    localparam int W1_W = VALUE_BITS + 1;
    localparam int H_W  = $clog2(VALUE_BITS + 1);
    localparam int M_W  = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] v;
    logic [W1_W-1:0]       w;
    logic [W1_W-1:0]       tail;
    logic [H_W-1:0]        h;
    logic [M_W-1:0]        m;
    logic [LEN_W-1:0]      len;
    logic [LEN_W-1:0]      sh;
    logic [CODE_W-1:0]     ones;

    // handshake toward the queue
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // offset value, its top bit position gives the prefix length
    assign v = VALUE_BITS'(i_in_word.value);
    assign w = {1'b0, v} + W1_W'(2);

    always_comb begin
        h = '0;
        for (int b = 1; b <= VALUE_BITS; b++) begin
            if (w[b]) begin
                h = H_W'(b);
            end
        end
    end

    assign m   = M_W'(h - H_W'(1));
    assign len = LEN_W'(m) + LEN_W'(m) + LEN_W'(2);
    assign sh  = LEN_W'(CODE_W) - len;

    // prefix ones, a zero, then the offset value without its leading one
    assign ones = ~({CODE_W{1'b1}} >> m);
    assign tail = w ^ ((W1_W'(1) << m) << 1);

    always_comb begin
        if (i_in_word.cmd == CMD_FLUSH) begin
            o_cmd  = CMD_FLUSH;
            o_code = '0;
            o_len  = '0;
        end else begin
            o_cmd  = CMD_ENCODE;
            o_code = ones | (CODE_W'(tail) << sh);
            o_len  = len;
        end
    end

endmodule

### src/egb_queue.sv
// two-entry queue between front end and bit packer
module egb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### src/egb_back.sv
// back end: shifts code bits into bytes and drives the output register
module egb_back #(
    parameter int VALUE_BITS = egb_pkg::VALUE_BITS_DEF,
    parameter int CODE_W     = 2 * VALUE_BITS,
    parameter int LEN_W      = $clog2(2 * VALUE_BITS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  logic               i_q_cmd,
    input  logic [CODE_W-1:0]  i_q_code,
    input  logic [LEN_W-1:0]   i_q_len,
    output logic               o_q_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output egb_pkg::t_out_word o_out_word
);
    import egb_pkg::*;

    logic                r_busy, n_busy;
    logic                r_cmd;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [LEN_W-1:0]    r_left, n_left;
    logic [BYTE_W-1:0]   r_part, n_part;
    logic [2:0]          r_pos, n_pos;
    logic [INDEX_W-1:0]  r_index, n_index;
    logic                r_ovalid, n_ovalid;
    t_out_word           r_oword, n_oword;

    logic                out_free;
    logic [3:0]          room;
    logic [3:0]          take;
    logic [3:0]          pos_sum;
    logic [BYTE_W-1:0]   chunk;
    logic [BYTE_W-1:0]   part_sum;

    assign out_free    = !r_ovalid || !i_out_stall;
    assign o_q_pop     = !r_busy && i_q_valid;
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    // bits that fit into the pending byte this cycle
    assign room     = 4'd8 - {1'b0, r_pos};
    assign take     = (r_left < LEN_W'(room)) ? 4'(r_left) : room;
    assign chunk    = r_code[CODE_W-1 -: BYTE_W] >> r_pos;
    assign part_sum = r_part | chunk;
    assign pos_sum  = {1'b0, r_pos} + take;

    // packer step
    always_comb begin
        n_busy   = r_busy;
        n_code   = r_code;
        n_left   = r_left;
        n_part   = r_part;
        n_pos    = r_pos;
        n_index  = r_index;
        n_ovalid = r_ovalid && i_out_stall;
        n_oword  = r_oword;
        if (o_q_pop) begin
            n_busy = 1'b1;
            n_code = i_q_code;
            n_left = i_q_len;
        end else if (r_busy && out_free) begin
            if (r_cmd == CMD_FLUSH) begin
                if (r_pos != 3'd0) begin
                    n_ovalid           = 1'b1;
                    n_oword.out_byte   = r_part;
                    n_oword.byte_index = r_index;
                    n_oword.last       = 1'b1;
                end
                n_part  = '0;
                n_pos   = '0;
                n_index = '0;
                n_busy  = 1'b0;
            end else begin
                n_code = r_code << room;
                n_left = r_left - LEN_W'(take);
                if (pos_sum == 4'd8) begin
                    n_ovalid           = 1'b1;
                    n_oword.out_byte   = part_sum;
                    n_oword.byte_index = r_index;
                    n_oword.last       = 1'b0;
                    n_index            = r_index + INDEX_W'(1);
                    n_part             = '0;
                    n_pos              = '0;
                end else begin
                    n_part = part_sum;
                    n_pos  = pos_sum[2:0];
                end
                if (r_left == LEN_W'(take)) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_part   <= '0;
            r_pos    <= '0;
            r_index  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_part   <= n_part;
            r_pos    <= n_pos;
            r_index  <= n_index;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        r_code  <= n_code;
        r_left  <= n_left;
        r_oword <= n_oword;
    end

    // unused low bits of the pending byte stay clear
    a_part_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_part & (8'hFF >> r_pos)) == 8'h00)
        else $error("pending byte has bits beyond its fill position");

    // a last byte always leaves the stream restarted at index zero
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oword.last) |-> (r_index == '0))
        else $error("byte index not restarted after flush");

    // an encode in progress still has code bits left
    a_encode_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cmd == CMD_ENCODE) |-> (r_left != '0))
        else $error("encode busy with no bits left");

    // no step happens while a stalled byte is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |=> $stable(r_oword))
        else $error("held output byte overwritten");

endmodule

### src/exp_golomb_bit_packer.sv
// Top level of the order-1 exp-Golomb bit packer.
// A word enters the queue at acceptance and is loaded by the packer once it is idle; each step
// shifts code bits into the pending byte, and a filled byte is registered into the output
// register. A word takes a load and then a step for each byte its code touches; a flush takes a
// load and a step. The packer moves at most one byte-fill of code bits per cycle, none while stalled.
// Reset (synchronous, active low) empties the queue, clears the pending byte and restarts index 0.
module exp_golomb_bit_packer #(
    parameter int VALUE_BITS = egb_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  egb_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output egb_pkg::t_out_word o_out_word
);
    import egb_pkg::*;

    localparam int CODE_W = 2 * VALUE_BITS;
    localparam int LEN_W  = $clog2(2 * VALUE_BITS + 1);
    localparam int ENT_W  = 1 + CODE_W + LEN_W;

    logic              push;
    logic              f_cmd;
    logic [CODE_W-1:0] f_code;
    logic [LEN_W-1:0]  f_len;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [ENT_W-1:0]  q_data;

    // front end
    egb_front #(
        .VALUE_BITS (VALUE_BITS),
        .CODE_W     (CODE_W),
        .LEN_W      (LEN_W)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cmd      (f_cmd),
        .o_code     (f_code),
        .o_len      (f_len)
    );

    // queue between front and packer
    egb_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_code, f_len}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // bit packer
    egb_back #(
        .VALUE_BITS (VALUE_BITS),
        .CODE_W     (CODE_W),
        .LEN_W      (LEN_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_data[ENT_W-1]),
        .i_q_code    (q_data[LEN_W +: CODE_W]),
        .i_q_len     (q_data[LEN_W-1:0]),
        .o_q_pop     (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

### tb/tb_exp_golomb_bit_packer.sv
// testbench for the order-1 exp-golomb bit packer: directed table, random streams, byte checker
`timescale 1ns / 100ps

module tb_exp_golomb_bit_packer;
    import egb_pkg::*;

    localparam int N_RANDOM    = 440;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_WAIT  = 20;
    localparam int N_DIRECTED  = 21;

    // one directed stimulus row; typed rows carry their bytes, first byte in the top lane
    typedef struct {
        logic               cmd;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        int                 n_typed;
        logic [31:0]        typed_bytes;
        logic [INDEX_W-1:0] typed_index;
        logic               typed_last;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_word  o_out_word;

    // packer state mirror
    logic [2:0]         pk_fill;
    logic [BYTE_W-1:0]  pk_byte;
    logic [INDEX_W-1:0] pk_index;

    t_out_word bytes_due[$];
    t_out_word fresh_bytes[$];
    t_out_word got_word;
    t_out_word want_word;
    int        n_fail;
    bit        hold_req;
    bit        quiet;

    t_stim_row dir_rows [N_DIRECTED] = '{
        '{CMD_FLUSH,  16'hFFFF, 1'b1, 0, 32'h0000_0000, 24'h0, 1'b0}, // nothing pending
        '{CMD_ENCODE, 16'h0000, 1'b1, 0, 32'h0000_0000, 24'h0, 1'b0}, // two bits, no byte
        '{CMD_FLUSH,  16'h0000, 1'b1, 1, 32'h0000_0000, 24'h0, 1'b1}, // padded partial byte
        '{CMD_ENCODE, 16'hFFFF, 1'b1, 4, 32'hFFFE_0001, 24'h0, 1'b0}, // longest code
        '{CMD_FLUSH,  16'h1234, 1'b1, 0, 32'h0000_0000, 24'h0, 1'b0}, // aligned, index restarts
        '{CMD_ENCODE, 16'hFFFE, 1'b1, 4, 32'hFFFE_0000, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h0001, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h0002, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h0005, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h0006, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h7FFF, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h8000, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'hAAAA, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h5555, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h0101, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_FLUSH,  16'h0000, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h0003, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h000D, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_ENCODE, 16'h000E, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_FLUSH,  16'hFFFF, 1'b0, 0, 32'h0, 24'h0, 1'b0},
        '{CMD_FLUSH,  16'h0000, 1'b0, 0, 32'h0, 24'h0, 1'b0}  // second flush in a row
    };

    exp_golomb_bit_packer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    // code one word into bytes, updating the packer mirror
    task automatic pack_word(input t_in_word w);
        longint unsigned v;
        longint unsigned rem;
        longint unsigned code;
        int              m;
        int              i;
        t_out_word       ob;
        fresh_bytes.delete();
        if (w.cmd == CMD_FLUSH) begin
            if (pk_fill != 3'd0) begin
                ob.out_byte   = pk_byte;
                ob.byte_index = pk_index;
                ob.last       = 1'b1;
                fresh_bytes.push_back(ob);
            end
            pk_fill  = 3'd0;
            pk_byte  = '0;
            pk_index = '0;
        end else begin
            v = longint'(w.value) & ((64'd1 << VALUE_BITS_DEF) - 64'd1);
            m = 0;
            while (v >= ((64'd2 << (m + 1)) - 64'd2)) m++;
            rem  = v - ((64'd2 << m) - 64'd2);
            // m ones, a zero, then the remainder in m+1 bits
            code = (((64'd1 << m) - 64'd1) << (m + 2)) | rem;
            for (i = 2 * m + 1; i >= 0; i--) begin
                pk_byte[7 - pk_fill] = code[i];
                if (pk_fill == 3'd7) begin
                    ob.out_byte   = pk_byte;
                    ob.byte_index = pk_index;
                    ob.last       = 1'b0;
                    fresh_bytes.push_back(ob);
                    pk_index = pk_index + 24'd1;
                    pk_byte  = '0;
                end
                pk_fill = pk_fill + 3'd1;
            end
        end
    endtask

    // offer one word, hold it until taken, then run it through the mirror and, if predicted, record its bytes
    task automatic send_word(input t_in_word w, input bit predicted);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        pack_word(w);
        if (predicted) begin
            foreach (fresh_bytes[n]) bytes_due.push_back(fresh_bytes[n]);
        end
    endtask

    // receiver stall pattern
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_word = o_out_word;
            if (bytes_due.size() == 0) begin
                $error("unexpected word: out_byte %h byte_index %0d last %b",
                       got_word.out_byte, got_word.byte_index, got_word.last);
                n_fail++;
            end else begin
                want_word = bytes_due.pop_front();
                if (got_word.out_byte !== want_word.out_byte) begin
                    $error("out_byte: expected %h, got %h",
                           want_word.out_byte, got_word.out_byte);
                    n_fail++;
                end
                if (got_word.byte_index !== want_word.byte_index) begin
                    $error("byte_index: expected %0d, got %0d",
                           want_word.byte_index, got_word.byte_index);
                    n_fail++;
                end
                if (got_word.last !== want_word.last) begin
                    $error("last: expected %b, got %b", want_word.last, got_word.last);
                    n_fail++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_in_word  w;
        t_out_word ob;
        int        k;
        int        j;
        int        stream_left;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        n_fail     = 0;
        hold_req   = 1'b0;
        quiet      = 1'b0;
        pk_fill    = 3'd0;
        pk_byte    = '0;
        pk_index   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (k = 0; k < N_DIRECTED; k++) begin
            w.cmd   = dir_rows[k].cmd;
            w.value = dir_rows[k].value;
            send_word(w, !dir_rows[k].typed);
            if (dir_rows[k].typed) begin
                for (j = 0; j < dir_rows[k].n_typed; j++) begin
                    ob.out_byte   = dir_rows[k].typed_bytes[31 - 8 * j -: 8];
                    ob.byte_index = dir_rows[k].typed_index + 24'(j);
                    ob.last       = dir_rows[k].typed_last;
                    bytes_due.push_back(ob);
                end
            end
        end

        // random streams: runs of values closed by a flush, with stray flushes mixed in
        stream_left = $urandom_range(1, 30);
        for (k = 0; k < N_RANDOM; k++) begin
            if (k == 120) hold_req = 1'b1;
            if (k == 300) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (bytes_due.size() != 0) @(posedge i_clk);
            end
            if (k >= N_RANDOM - 50) quiet = 1'b1;
            w.value = $urandom_range(0, 65535);
            if (stream_left == 0) begin
                w.cmd       = CMD_FLUSH;
                stream_left = $urandom_range(1, 30);
            end else begin
                stream_left--;
                w.cmd = ($urandom_range(0, 39) == 0) ? CMD_FLUSH : CMD_ENCODE;
                case ($urandom_range(0, 4))
                    0: w.value = $urandom_range(0, 15);
                    1: w.value = $urandom_range(0, 255);
                    2: w.value = $urandom_range(0, 4095);
                    3: ;
                    default: begin
                        case ($urandom_range(0, 3))
                            0: w.value = 16'h0000;
                            1: w.value = 16'h0001;
                            2: w.value = 16'hFFFE;
                            default: w.value = 16'hFFFF;
                        endcase
                    end
                endcase
            end
            send_word(w, 1'b1);
        end

        // drain
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
